/* rtl/dibpd_pkg.sv */
// dibpd_pkg: shared constants and widths for the icon pixel decoder
// no dependencies; imported by the interfaces and the top level
`default_nettype none

package dibpd_pkg;

  localparam int FMT_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int COLOUR_W  = 24;
  localparam int ARGB_W    = 32;

  localparam logic [FMT_W-1:0] FMT_1BPP  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_24BPP = 3'd3;
  localparam logic [FMT_W-1:0] FMT_32BPP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 2'd1;

  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

endpackage

`default_nettype wire

/* rtl/dibpd_if.sv */
// dibpd_if: valid/ready channel interfaces for pixel input, argb output and config writes
// depends on dibpd_pkg
`default_nettype none

interface dibpd_in_if
  import dibpd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                action;
  logic [7:0]          pal_index;
  logic [COLOUR_W-1:0] pal_colour;
  logic [7:0]          pixel_x;
  logic [31:0]         colour_data;
  logic [7:0]          mask_byte;

  modport source (output valid, action, pal_index, pal_colour, pixel_x, colour_data,
                  mask_byte, input ready);
  modport sink   (input valid, action, pal_index, pal_colour, pixel_x, colour_data,
                  mask_byte, output ready);
endinterface

interface dibpd_out_if
  import dibpd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] argb;

  modport source (output valid, argb, input ready);
  modport sink   (input valid, argb, output ready);
endinterface

interface dibpd_cfg_if
  import dibpd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/dib_icon_pixel_decode.sv */
// dib_icon_pixel_decode: icon/cursor bitmap pixel to 32-bit ARGB converter
// an accepted pixel beat is registered in stage 1, then in the result register that drives its result beat
// throughput one beat per cycle while the result side is not stalled; palette writes give no result
// the registered palette read port (stage 1) and the result register are the two stages
// rst_n (synchronous, active low) clears valids and sets 8bpp, mask alpha
// depends on dibpd_pkg and dibpd_if
`default_nettype none

module dib_icon_pixel_decode
  import dibpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire          clk,
  input  wire          rst_n,
  dibpd_in_if.sink     in_ch,
  dibpd_out_if.source  out_ch,
  dibpd_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [FMT_W-1:0]    fmt_r;
  logic                alpha_mode_r;

  logic [COLOUR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOUR_W-1:0] pal_rd_r;

  logic                s1_v_r;
  logic                s1_direct_r;
  logic                s1_oob_r;
  logic [COLOUR_W-1:0] s1_raw_r;
  logic [7:0]          s1_alpha_r;

  logic                out_v_r;
  logic [ARGB_W-1:0]   argb_r;
  logic [ARGB_W-1:0]   argb_nxt;

  logic                advance;
  logic                in_acc;
  logic                pix_acc;
  logic                wr_ok;
  logic [7:0]          pick_idx;
  logic                rd_ok;
  logic                pal_fmt;
  logic                use_stored;
  logic                mask_bit;
  logic [7:0]          alpha_nxt;
  logic [COLOUR_W-1:0] rgb_s1;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pix_acc      = in_acc && (in_ch.action == ACT_PIXEL);
  assign cfg_ch.ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= FMT_8BPP;
      alpha_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PIXEL_FORMAT: fmt_r        <= cfg_ch.data[FMT_W-1:0];
        REG_ALPHA_MODE:   alpha_mode_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // palette index extraction, msb first
  assign pal_fmt = (fmt_r == FMT_1BPP) || (fmt_r == FMT_4BPP) || (fmt_r == FMT_8BPP);

  always_comb begin
    case (fmt_r)
      FMT_8BPP: pick_idx = in_ch.colour_data[7:0];
      FMT_4BPP: pick_idx = in_ch.pixel_x[0] ? {4'h0, in_ch.colour_data[3:0]}
                                            : {4'h0, in_ch.colour_data[7:4]};
      default:  pick_idx = {7'h00, in_ch.colour_data[~in_ch.pixel_x[2:0]]};
    endcase
  end

  assign wr_ok = int'(in_ch.pal_index) < PALETTE_DEPTH;
  assign rd_ok = int'(pick_idx) < PALETTE_DEPTH;

  // alpha select
  assign use_stored = !pal_fmt && (fmt_r != FMT_24BPP) && alpha_mode_r;
  assign mask_bit   = in_ch.mask_byte[~in_ch.pixel_x[2:0]];
  assign alpha_nxt  = use_stored ? in_ch.colour_data[31:24]
                                 : (mask_bit ? ALPHA_CLEAR : ALPHA_OPAQUE);

  // palette memory
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.action == ACT_PAL_WRITE) && wr_ok) begin
      pal_mem[in_ch.pal_index[AW-1:0]] <= in_ch.pal_colour;
    end
    if (pix_acc) begin
      pal_rd_r <= pal_mem[pick_idx[AW-1:0]];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_direct_r <= !pal_fmt;
      s1_oob_r    <= !rd_ok;
      s1_raw_r    <= in_ch.colour_data[COLOUR_W-1:0];
      s1_alpha_r  <= alpha_nxt;
    end
  end

  assign rgb_s1   = s1_direct_r ? s1_raw_r : (s1_oob_r ? '0 : pal_rd_r);
  assign argb_nxt = {s1_alpha_r, rgb_s1};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      argb_r <= argb_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.argb  = argb_r;

endmodule

`default_nettype wire

/* rtl/dibpd_checker.sv */
// dibpd_checker: port-level assertions for dib_icon_pixel_decode
// depends on dibpd_pkg; bound to the top level below
`default_nettype none

module dibpd_checker
  import dibpd_pkg::*;
(
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire in_action,
  input wire out_valid,
  input wire out_ready
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // no pending result means the input side is open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a newly offered result beat comes from an accepted pixel beat
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_action == ACT_PIXEL), 2))
    else $error("result beat without pixel beat");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dib_icon_pixel_decode dibpd_checker u_dibpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

/* bench/dib_icon_pixel_decode_tb.sv */
// testbench for dib_icon_pixel_decode: palette, direct-colour and alpha decoding to argb
// self-checking against an in-bench predictor, random input gaps and random back-pressure on the result side
// depends on dibpd_pkg, dibpd_if and the dib_icon_pixel_decode top level
module dib_icon_pixel_decode_tb;
  import dibpd_pkg::*;

  localparam int PIPE_LATENCY  = 2;
  localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_SHOWN     = 40;

  typedef struct packed {
    logic                action;
    logic [7:0]          pal_index;
    logic [COLOUR_W-1:0] pal_colour;
    logic [7:0]          pixel_x;
    logic [31:0]         colour_data;
    logic [7:0]          mask_byte;
  } dib_beat_t;

  logic clk;
  logic rst_n;

  dibpd_in_if  in_bus ();
  dibpd_out_if out_bus ();
  dibpd_cfg_if cfg_bus ();

  dib_icon_pixel_decode DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  logic [FMT_W-1:0]    cur_fmt   = FMT_8BPP;
  logic                cur_alpha = 1'b0;
  logic [COLOUR_W-1:0] palette_copy [256];
  bit                  palette_loaded [256];
  logic [ARGB_W-1:0]   pending_argb [$];
  dib_beat_t           seen_beat;
  logic [ARGB_W-1:0]   want_argb;
  int                  errors = 0;
  int                  cycle_count = 0;
  bit                  no_idle = 1'b0;
  bit                  hold_pending = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_index(logic [7:0] packed_byte, logic [7:0] x,
                                            logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_8BPP: return packed_byte;
      FMT_4BPP: return x[0] ? {4'h0, packed_byte[3:0]} : {4'h0, packed_byte[7:4]};
      default:  return {7'd0, packed_byte[3'd7 - x[2:0]]};
    endcase
  endfunction

  function automatic logic [ARGB_W-1:0] decode_argb(dib_beat_t b);
    logic [2:0]          bitpos;
    logic [COLOUR_W-1:0] rgb;
    logic [7:0]          alpha;
    logic                stored;
    bitpos = 3'd7 - b.pixel_x[2:0];
    stored = 1'b0;
    if (cur_fmt <= FMT_8BPP) begin
      rgb = palette_copy[pick_index(b.colour_data[7:0], b.pixel_x, cur_fmt)];
    end else begin
      rgb = b.colour_data[23:0];
      stored = (cur_fmt != FMT_24BPP) && cur_alpha;
    end
    if (stored) alpha = b.colour_data[31:24];
    else alpha = b.mask_byte[bitpos] ? ALPHA_CLEAR : ALPHA_OPAQUE;
    return {alpha, rgb};
  endfunction

  function automatic dib_beat_t pal_write_beat(logic [7:0] idx, logic [COLOUR_W-1:0] colour);
    dib_beat_t b;
    b.action      = ACT_PAL_WRITE;
    b.pal_index   = idx;
    b.pal_colour  = colour;
    b.pixel_x     = 8'($urandom);
    b.colour_data = $urandom;
    b.mask_byte   = 8'($urandom);
    return b;
  endfunction

  function automatic dib_beat_t pixel_beat(logic [7:0] x, logic [31:0] data, logic [7:0] mask);
    dib_beat_t b;
    b.action      = ACT_PIXEL;
    b.pal_index   = 8'($urandom);
    b.pal_colour  = COLOUR_W'($urandom);
    b.pixel_x     = x;
    b.colour_data = data;
    b.mask_byte   = mask;
    return b;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (errors < MAX_SHOWN)
      $display("mismatch %s at cycle %0d: expected %08h got %08h", what, cycle_count, want, got);
    errors++;
  endtask

  // predictor: palette writes update the copy; one expectation per accepted pixel beat
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      seen_beat = {in_bus.action, in_bus.pal_index, in_bus.pal_colour, in_bus.pixel_x,
                   in_bus.colour_data, in_bus.mask_byte};
      if (seen_beat.action == ACT_PAL_WRITE)
        palette_copy[seen_beat.pal_index] = seen_beat.pal_colour;
      else pending_argb = {pending_argb, decode_argb(seen_beat)};
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_argb.size() == 0) begin
        flag_mismatch("unexpected beat", '0, out_bus.argb);
      end else begin
        want_argb = pending_argb.pop_front();
        if (out_bus.argb !== want_argb) flag_mismatch("argb", want_argb, out_bus.argb);
      end
    end
  end

  // result side ready, with random stalls and a long hold on request
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          out_bus.ready <= 1'b1;
        end else begin
          out_bus.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_beat(input dib_beat_t b);
    int gap;
    if (b.action == ACT_PAL_WRITE) palette_loaded[b.pal_index] = 1'b1;
    in_bus.valid       <= 1'b1;
    in_bus.action      <= b.action;
    in_bus.pal_index   <= b.pal_index;
    in_bus.pal_colour  <= b.pal_colour;
    in_bus.pixel_x     <= b.pixel_x;
    in_bus.colour_data <= b.colour_data;
    in_bus.mask_byte   <= b.mask_byte;
    do @(posedge clk); while (!in_bus.ready);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // never read an unwritten palette entry: load it first
  task automatic send_pixel(input dib_beat_t b);
    logic [7:0] idx;
    if (cur_fmt <= FMT_8BPP) begin
      idx = pick_index(b.colour_data[7:0], b.pixel_x, cur_fmt);
      if (!palette_loaded[idx]) send_beat(pal_write_beat(idx, COLOUR_W'($urandom)));
    end
    send_beat(b);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_argb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_PIXEL_FORMAT) cur_fmt = value[FMT_W-1:0];
    else if (idx == REG_ALPHA_MODE) cur_alpha = value[0];
  endtask

  task automatic set_format(input logic [FMT_W-1:0] fmt);
    logic [CFG_DAT_W-FMT_W-1:0] junk;
    junk = (CFG_DAT_W-FMT_W)'($urandom);
    write_reg(REG_PIXEL_FORMAT, {junk, fmt});
  endtask

  task automatic set_alpha(input logic mode);
    logic [CFG_DAT_W-2:0] junk;
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_ALPHA_MODE, {junk, mode});
  endtask

  task automatic test_reset_defaults();
    logic [23:0] upper;
    upper = 24'($urandom);
    send_beat(pal_write_beat(8'd0, 24'h000000));
    send_beat(pal_write_beat(8'd255, 24'hFFFFFF));
    send_beat(pal_write_beat(8'h5A, COLOUR_W'($urandom)));
    send_pixel(pixel_beat(8'd0, 32'h000000FF, 8'hFF));
    send_pixel(pixel_beat(8'd3, 32'hFFFFFF00, 8'h00));
    send_pixel(pixel_beat(8'hFF, {upper, 8'h5A}, 8'($urandom)));
  endtask

  task automatic test_palette_depths();
    set_format(FMT_1BPP);
    send_beat(pal_write_beat(8'd1, COLOUR_W'($urandom)));
    send_pixel(pixel_beat(8'd0, 32'h00000080, 8'h80));
    send_pixel(pixel_beat(8'd7, 32'h00000001, 8'h00));
    send_pixel(pixel_beat(8'd8, 32'h0000007F, 8'h7F));
    set_format(FMT_4BPP);
    send_beat(pal_write_beat(8'd15, COLOUR_W'($urandom)));
    send_pixel(pixel_beat(8'd0, 32'h000000F0, 8'h00));
    send_pixel(pixel_beat(8'd1, 32'h000000F0, 8'h40));
    send_pixel(pixel_beat(8'd255, 32'h0000000F, 8'hFF));
  endtask

  task automatic test_direct_depths();
    set_format(FMT_24BPP);
    set_alpha(1'b0);
    send_pixel(pixel_beat(8'd0, 32'hFFFFFFFF, 8'h00));
    set_alpha(1'b1);
    send_pixel(pixel_beat(8'd7, 32'h00ABCDEF, 8'h01));
    set_format(FMT_32BPP);
    send_pixel(pixel_beat(8'h40, 32'h12345678, 8'hFF));
    send_pixel(pixel_beat(8'h13, 32'hFF000000, 8'h00));
    set_alpha(1'b0);
    send_pixel(pixel_beat(8'd0, 32'hAA55AA55, 8'h80));
  endtask

  task automatic test_unused_formats();
    for (int f = 5; f < 8; f++) begin
      set_format(FMT_W'(f));
      set_alpha(f[0]);
      send_pixel(pixel_beat(8'($urandom), $urandom, 8'($urandom)));
    end
  endtask

  task automatic test_palette_fill();
    for (int i = 0; i < 256; i++) send_beat(pal_write_beat(8'(i), COLOUR_W'($urandom)));
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 16; p++) begin
      set_format(FMT_W'(p));
      set_alpha(p[3]);
      no_idle = (p % 5 == 2);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 || $urandom_range(0, 199) == 0) drain_results();
        if ($urandom_range(0, 99) < 15)
          send_beat(pal_write_beat(8'($urandom), COLOUR_W'($urandom)));
        else send_pixel(pixel_beat(8'($urandom), $urandom, 8'($urandom)));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_format(FMT_4BPP);
    set_alpha(1'b0);
    no_idle = 1'b1;
    hold_pending = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel(pixel_beat(8'($urandom), $urandom, 8'($urandom)));
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= ACT_PAL_WRITE;
    in_bus.pal_index   <= '0;
    in_bus.pal_colour  <= '0;
    in_bus.pixel_x     <= '0;
    in_bus.colour_data <= '0;
    in_bus.mask_byte   <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_PIXEL_FORMAT;
    cfg_bus.data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_palette_depths();
    test_direct_depths();
    test_unused_formats();
    test_palette_fill();
    test_random_mix();
    test_backpressure();
    drain_results();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
